### hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Operation codes, reserved value and priority codes, field widths and the
// entry and status structs used between the sequencer, store and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;

   localparam int KIND_W  = 3;
   localparam int VALUE_W = 8;
   localparam int PRIO_W  = 16;

   localparam logic [KIND_W-1:0] KIND_INSERT  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DEQUEUE = 3'd2;
   localparam logic [KIND_W-1:0] KIND_REFILL  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd4;

   localparam logic [VALUE_W-1:0] NO_VALUE = 8'hFF;
   localparam logic [PRIO_W-1:0]  NO_PRIO  = 16'hFFFF;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [PRIO_W-1:0]  prio;
   } entry_type;

   typedef struct packed {
      logic [VALUE_W-1:0] out_value;
      logic               was_empty;
      logic [PRIO_W-1:0]  head_priority;
      logic               full_reject;
   } status_type;

endpackage

`default_nettype wire

### hdl/spq_if.sv
// ----------------------------------------------------------------------------
// spq_if: request and response channels of the sorted priority queue
// Valid/ready channels; a transaction moves when valid and ready are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface spq_req_if;
   logic                       valid;
   logic                       ready;
   logic [spq_pkg::KIND_W-1:0] kind;
   logic [spq_pkg::VALUE_W-1:0] item_value;
   logic [spq_pkg::PRIO_W-1:0]  item_priority;

   modport source (output valid, output kind, output item_value,
                   output item_priority, input ready);
   modport sink   (input valid, input kind, input item_value,
                   input item_priority, output ready);
endinterface

interface spq_rsp_if #(
   parameter int COUNT_W = $clog2(spq_pkg::QUEUE_DEPTH_DEF + 1)
);
   logic                        valid;
   logic                        ready;
   logic [spq_pkg::VALUE_W-1:0] out_value;
   logic                        was_empty;
   logic [spq_pkg::PRIO_W-1:0]  head_priority;
   logic [COUNT_W-1:0]          live_count;
   logic                        full_reject;

   modport source (output valid, output out_value, output was_empty,
                   output head_priority, output live_count,
                   output full_reject, input ready);
   modport sink   (input valid, input out_value, input was_empty,
                   input head_priority, input live_count,
                   input full_reject, output ready);
endinterface

`default_nettype wire

### hdl/spq_store.sv
// ----------------------------------------------------------------------------
// spq_store: entry memory of the sorted priority queue
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_store #(
   parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
   input  wire logic               clock,
   input  wire logic [AW-1:0]      rd_addr,
   output spq_pkg::entry_type      rd_data,
   input  wire logic               wr_en,
   input  wire logic [AW-1:0]      wr_addr,
   input  spq_pkg::entry_type      wr_data
);

   spq_pkg::entry_type mem [QUEUE_DEPTH];
   spq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hdl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl: sequencer of the sorted priority queue
// Walks the store one entry per read: search, bubble up or down, close the
// gap on remove, read at the cursor, and fetch the head priority.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ctrl #(
   parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
   localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [spq_pkg::KIND_W-1:0]  req_kind,
   input  wire logic [spq_pkg::VALUE_W-1:0] req_value,
   input  wire logic [spq_pkg::PRIO_W-1:0]  req_prio,
   input  wire logic                        slot_free,
   output logic                             idle,
   output logic                             done,
   output spq_pkg::status_type              status,
   output logic [CW-1:0]                    count,
   output logic [AW-1:0]                    rd_addr,
   input  spq_pkg::entry_type               rd_data,
   output logic                             wr_en,
   output logic [AW-1:0]                    wr_addr,
   output spq_pkg::entry_type               wr_data
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_SRCH_RD  = 4'd1;
   localparam logic [3:0] S_SRCH_CMP = 4'd2;
   localparam logic [3:0] S_UP_RD    = 4'd3;
   localparam logic [3:0] S_UP_CMP   = 4'd4;
   localparam logic [3:0] S_DN_RD    = 4'd5;
   localparam logic [3:0] S_DN_CMP   = 4'd6;
   localparam logic [3:0] S_PLACE    = 4'd7;
   localparam logic [3:0] S_RM_RD    = 4'd8;
   localparam logic [3:0] S_RM_WR    = 4'd9;
   localparam logic [3:0] S_DEQ_GET  = 4'd10;
   localparam logic [3:0] S_HEAD_RD  = 4'd11;
   localparam logic [3:0] S_HEAD_GET = 4'd12;
   localparam logic [3:0] S_DONE     = 4'd13;

   localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
   localparam logic [CW-1:0] ONE_C   = CW'(1);

   logic [3:0]                   state_ff,  state_in;
   logic [spq_pkg::KIND_W-1:0]   kind_ff,   kind_in;
   logic [spq_pkg::VALUE_W-1:0]  val_ff,    val_in;
   logic [spq_pkg::PRIO_W-1:0]   prio_ff,   prio_in;
   logic [CW-1:0]                pos_ff,    pos_in;
   logic [CW-1:0]                idx_ff,    idx_in;
   logic [CW-1:0]                count_ff,  count_in;
   logic [CW-1:0]                cursor_ff, cursor_in;
   logic                         empty_ff,  empty_in;
   logic [spq_pkg::VALUE_W-1:0]  outv_ff,   outv_in;
   logic                         reject_ff, reject_in;
   logic [spq_pkg::PRIO_W-1:0]   head_ff,   head_in;

   logic [CW-1:0] pos_m1;
   logic [CW-1:0] pos_p1;

   assign pos_m1 = pos_ff - ONE_C;
   assign pos_p1 = pos_ff + ONE_C;

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      val_in    = val_ff;
      prio_in   = prio_ff;
      pos_in    = pos_ff;
      idx_in    = idx_ff;
      count_in  = count_ff;
      cursor_in = cursor_ff;
      empty_in  = empty_ff;
      outv_in   = outv_ff;
      reject_in = reject_ff;
      head_in   = head_ff;
      rd_addr   = cursor_ff[AW-1:0];
      wr_en     = 1'b0;
      wr_addr   = pos_ff[AW-1:0];
      wr_data   = rd_data;
      done      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               kind_in   = req_kind;
               val_in    = req_value;
               prio_in   = req_prio;
               idx_in    = '0;
               empty_in  = (cursor_ff >= count_ff);
               outv_in   = spq_pkg::NO_VALUE;
               reject_in = 1'b0;
               unique case (req_kind) inside
                  spq_pkg::KIND_INSERT, spq_pkg::KIND_REMOVE: begin
                     state_in = S_SRCH_RD;
                  end
                  spq_pkg::KIND_DEQUEUE: begin
                     if (cursor_ff < count_ff) begin
                        rd_addr  = cursor_ff[AW-1:0];
                        state_in = S_DEQ_GET;
                     end else begin
                        state_in = S_HEAD_RD;
                     end
                  end
                  spq_pkg::KIND_REFILL: begin
                     cursor_in = '0;
                     state_in  = S_HEAD_RD;
                  end
                  spq_pkg::KIND_CLEAR: begin
                     cursor_in = '0;
                     count_in  = '0;
                     state_in  = S_HEAD_RD;
                  end
                  default: begin
                     state_in = S_HEAD_RD;
                  end
               endcase
            end
         end
         S_SRCH_RD: begin
            if (idx_ff == count_ff) begin
               // value absent: append on insert (reject if full), nothing to do on remove
               pos_in = count_ff;
               if (kind_ff == spq_pkg::KIND_INSERT) begin
                  if (count_ff >= DEPTH_C) begin
                     reject_in = 1'b1;
                     state_in  = S_HEAD_RD;
                  end else begin
                     count_in = count_ff + ONE_C;
                     state_in = S_UP_RD;
                  end
               end else begin
                  state_in = S_HEAD_RD;
               end
            end else begin
               rd_addr  = idx_ff[AW-1:0];
               state_in = S_SRCH_CMP;
            end
         end
         S_SRCH_CMP: begin
            if (rd_data.value == val_ff) begin
               pos_in   = idx_ff;
               state_in = (kind_ff == spq_pkg::KIND_INSERT) ? S_UP_RD : S_RM_RD;
            end else begin
               idx_in   = idx_ff + ONE_C;
               state_in = S_SRCH_RD;
            end
         end
         S_UP_RD: begin
            if (pos_ff == '0) begin
               state_in = S_DN_RD;
            end else begin
               rd_addr  = pos_m1[AW-1:0];
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            // move the larger neighbor down one slot
            if (prio_ff < rd_data.prio) begin
               wr_en    = 1'b1;
               pos_in   = pos_m1;
               state_in = S_UP_RD;
            end else begin
               state_in = S_DN_RD;
            end
         end
         S_DN_RD: begin
            if (pos_p1 >= count_ff) begin
               state_in = S_PLACE;
            end else begin
               rd_addr  = pos_p1[AW-1:0];
               state_in = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            if (prio_ff > rd_data.prio) begin
               wr_en    = 1'b1;
               pos_in   = pos_p1;
               state_in = S_DN_RD;
            end else begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            wr_en         = 1'b1;
            wr_data.value = val_ff;
            wr_data.prio  = prio_ff;
            state_in      = S_HEAD_RD;
         end
         S_RM_RD: begin
            if (pos_p1 >= count_ff) begin
               // drop the last slot
               wr_en         = 1'b1;
               wr_data.value = spq_pkg::NO_VALUE;
               wr_data.prio  = spq_pkg::NO_PRIO;
               count_in      = count_ff - ONE_C;
               state_in      = S_HEAD_RD;
            end else begin
               rd_addr  = pos_p1[AW-1:0];
               state_in = S_RM_WR;
            end
         end
         S_RM_WR: begin
            wr_en    = 1'b1;
            pos_in   = pos_p1;
            state_in = S_RM_RD;
         end
         S_DEQ_GET: begin
            outv_in   = rd_data.value;
            cursor_in = cursor_ff + ONE_C;
            state_in  = S_HEAD_RD;
         end
         S_HEAD_RD: begin
            if (cursor_ff < count_ff) begin
               rd_addr  = cursor_ff[AW-1:0];
               state_in = S_HEAD_GET;
            end else begin
               head_in  = spq_pkg::NO_PRIO;
               state_in = S_DONE;
            end
         end
         S_HEAD_GET: begin
            head_in  = rd_data.prio;
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold until the response register is free
            if (slot_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         cursor_ff <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      val_ff    <= val_in;
      prio_ff   <= prio_in;
      pos_ff    <= pos_in;
      idx_ff    <= idx_in;
      empty_ff  <= empty_in;
      outv_ff   <= outv_in;
      reject_ff <= reject_in;
      head_ff   <= head_in;
   end

   assign idle                 = (state_ff == S_IDLE);
   assign count                = count_ff;
   assign status.out_value     = outv_ff;
   assign status.was_empty     = empty_ff;
   assign status.head_priority = head_ff;
   assign status.full_reject   = reject_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("entry count above queue depth");

   a_search_live: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SRCH_CMP |-> idx_ff < count_ff)
      else $error("search compared a slot beyond the live entries");

   a_deq_live: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DEQ_GET |-> cursor_ff < count_ff)
      else $error("dequeue read beyond the live entries");

   a_reject_full: assert property (@(posedge clock) disable iff (reset)
      done && reject_ff |-> kind_ff == spq_pkg::KIND_INSERT && count_ff == DEPTH_C)
      else $error("reject reported while the store was not full");

   a_bubble_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UP_CMP || state_ff == S_DN_CMP || state_ff == S_PLACE)
      |-> pos_ff < count_ff)
      else $error("bubble position outside the live entries");

endmodule

`default_nettype wire

### hdl/sorted_priority_queue_16.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_16: sorted array priority queue of value/priority pairs
// Insert, change priority, remove, dequeue through a cursor, refill and clear,
// with a status transaction for every request.
//
//  channel   dir  handshake          payload
//  req_chan  in   valid/ready        kind, item_value, item_priority
//  rsp_chan  out  valid/ready        out_value, was_empty, head_priority,
//                                    live_count, full_reject
//
// Store walks use the single store read port, whose data is registered.
// Reset clears count and cursor at once; the store needs no clearing pass.
// A request is taken only when the sequencer is idle; a finished status may
//   wait in the response register while the next request runs, and the
//   sequencer holds its result if that register is still occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_16 #(
   parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   spq_req_if.sink     req_chan,
   spq_rsp_if.source   rsp_chan
);

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic                idle;
   logic                done;
   logic                start;
   logic                slot_free;
   spq_pkg::status_type status;
   logic [CW-1:0]       count;
   logic [AW-1:0]       rd_addr;
   spq_pkg::entry_type  rd_data;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   spq_pkg::entry_type  wr_data;

   logic                rsp_valid_ff, rsp_valid_in;
   spq_pkg::status_type rsp_status_ff;
   logic [CW-1:0]       rsp_count_ff;

   assign start          = req_chan.valid && idle;
   assign req_chan.ready = idle;
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;

   spq_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_kind  (req_chan.kind),
      .req_value (req_chan.item_value),
      .req_prio  (req_chan.item_priority),
      .slot_free (slot_free),
      .idle      (idle),
      .done      (done),
      .status    (status),
      .count     (count),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   spq_store #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_status_ff <= status;
         rsp_count_ff  <= count;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.out_value     = rsp_status_ff.out_value;
   assign rsp_chan.was_empty     = rsp_status_ff.was_empty;
   assign rsp_chan.head_priority = rsp_status_ff.head_priority;
   assign rsp_chan.live_count    = rsp_count_ff;
   assign rsp_chan.full_reject   = rsp_status_ff.full_reject;

endmodule

`default_nettype wire

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench for sorted_priority_queue_16
// Drives insert, remove, dequeue, refill and clear requests over the request
// channel. A local copy of the sorted store predicts the status for every
// accepted request. Each response is checked field by field against the
// oldest prediction. Both channels idle at random, and the output is held
// off for a long stretch so that the response register fills and stalls the input.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QDEPTH     = spq_pkg::QUEUE_DEPTH_DEF;
   localparam int TAIL_WAIT  = 80;

   typedef struct packed {
      logic [spq_pkg::VALUE_W-1:0] out_value;
      logic                        was_empty;
      logic [spq_pkg::PRIO_W-1:0]  head_priority;
      logic [4:0]                  live_count;
      logic                        full_reject;
   } queue_status_type;

   logic clock = 1'b0;
   logic reset;

   spq_req_if req_chan ();
   spq_rsp_if rsp_chan ();

   sorted_priority_queue_16 dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // local copy of the sorted store
   logic [spq_pkg::VALUE_W-1:0] shadow_value [QDEPTH];
   logic [spq_pkg::PRIO_W-1:0]  shadow_prio  [QDEPTH];
   int                          shadow_cursor;
   int                          shadow_count;

   queue_status_type pending_status [$];
   int               fail_count = 0;
   bit               idle_on = 1'b1;
   int               hold_off_len = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void wipe_shadow();
      for (int k = 0; k < QDEPTH; k++) begin
         shadow_value[k] = spq_pkg::NO_VALUE;
         shadow_prio[k]  = spq_pkg::NO_PRIO;
      end
      shadow_cursor = 0;
      shadow_count  = 0;
   endfunction

   function automatic int locate_value(logic [spq_pkg::VALUE_W-1:0] v);
      for (int k = 0; k < shadow_count; k++) begin
         if (shadow_value[k] == v) return k;
      end
      return shadow_count;
   endfunction

   // Apply one request to the shadow store and return the status it produces.
   function automatic queue_status_type next_status(logic [spq_pkg::KIND_W-1:0] k,
                                                    logic [spq_pkg::VALUE_W-1:0] v,
                                                    logic [spq_pkg::PRIO_W-1:0] p);
      queue_status_type st;
      int               pos;
      st.out_value   = spq_pkg::NO_VALUE;
      st.full_reject = 1'b0;
      st.was_empty   = (shadow_cursor >= shadow_count);
      case (k)
         spq_pkg::KIND_INSERT: begin
            pos = locate_value(v);
            if (pos == shadow_count) begin
               if (shadow_count >= QDEPTH) st.full_reject = 1'b1;
               else shadow_count++;
            end
            if (!st.full_reject) begin
               // bubble up past strictly larger, then down past strictly smaller
               while (pos > 0 && p < shadow_prio[pos-1]) begin
                  shadow_value[pos] = shadow_value[pos-1];
                  shadow_prio[pos]  = shadow_prio[pos-1];
                  pos--;
               end
               while (pos + 1 < shadow_count && p > shadow_prio[pos+1]) begin
                  shadow_value[pos] = shadow_value[pos+1];
                  shadow_prio[pos]  = shadow_prio[pos+1];
                  pos++;
               end
               shadow_value[pos] = v;
               shadow_prio[pos]  = p;
            end
         end
         spq_pkg::KIND_REMOVE: begin
            pos = locate_value(v);
            if (pos < shadow_count) begin
               while (pos + 1 < shadow_count) begin
                  shadow_value[pos] = shadow_value[pos+1];
                  shadow_prio[pos]  = shadow_prio[pos+1];
                  pos++;
               end
               shadow_value[pos] = spq_pkg::NO_VALUE;
               shadow_prio[pos]  = spq_pkg::NO_PRIO;
               shadow_count--;
            end
         end
         spq_pkg::KIND_DEQUEUE: begin
            if (!st.was_empty) begin
               st.out_value = shadow_value[shadow_cursor];
               shadow_cursor++;
            end
         end
         spq_pkg::KIND_REFILL: shadow_cursor = 0;
         spq_pkg::KIND_CLEAR:  wipe_shadow();
         default: ;
      endcase
      st.head_priority = (shadow_cursor < shadow_count) ? shadow_prio[shadow_cursor]
                                                        : spq_pkg::NO_PRIO;
      st.live_count    = shadow_count[4:0];
      return st;
   endfunction

   // Offer one request, hold it until accepted, then maybe idle.
   task automatic send_item(input logic [spq_pkg::KIND_W-1:0] k,
                            input logic [spq_pkg::VALUE_W-1:0] v,
                            input logic [spq_pkg::PRIO_W-1:0] p);
      req_chan.valid         <= 1'b1;
      req_chan.kind          <= k;
      req_chan.item_value    <= v;
      req_chan.item_priority <= p;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pending_status.push_back(next_status(k, v, p));
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // Drop valid and wait for every outstanding status.
   task automatic drain_queue();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_status.size() != 0) @(posedge clock);
   endtask

   function automatic logic [spq_pkg::VALUE_W-1:0] pick_value(int span);
      if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 254));
      return 8'($urandom_range(0, span - 1));
   endfunction

   function automatic logic [spq_pkg::PRIO_W-1:0] pick_priority();
      case ($urandom_range(0, 4))
         0:       return 16'($urandom_range(0, 7));
         1:       return $urandom_range(0, 1) ? 16'd0 : 16'd65534;
         default: return 16'($urandom_range(0, 65534));
      endcase
   endfunction

   task automatic run_random(input int n_items, input int span);
      int                         sel;
      logic [spq_pkg::KIND_W-1:0] k;
      for (int i = 0; i < n_items; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 45)      k = spq_pkg::KIND_INSERT;
         else if (sel < 65) k = spq_pkg::KIND_REMOVE;
         else if (sel < 88) k = spq_pkg::KIND_DEQUEUE;
         else if (sel < 98) k = spq_pkg::KIND_REFILL;
         else               k = spq_pkg::KIND_CLEAR;
         send_item(k, pick_value(span), pick_priority());
      end
   endtask

   task automatic test_empty_store();
      send_item(spq_pkg::KIND_DEQUEUE, 8'd0, 16'd0);
      send_item(spq_pkg::KIND_REMOVE, 8'd7, 16'd0);
      send_item(spq_pkg::KIND_REFILL, 8'd0, 16'd0);
      send_item(spq_pkg::KIND_CLEAR, 8'd0, 16'd0);
      drain_queue();
   endtask

   task automatic test_ordering();
      send_item(spq_pkg::KIND_INSERT, 8'd0, 16'd0);
      send_item(spq_pkg::KIND_INSERT, 8'd254, 16'd65534);
      send_item(spq_pkg::KIND_INSERT, 8'd1, 16'd100);
      send_item(spq_pkg::KIND_INSERT, 8'd2, 16'd100);
      // raised number settles before equals, lowered number after them
      send_item(spq_pkg::KIND_INSERT, 8'd0, 16'd100);
      send_item(spq_pkg::KIND_INSERT, 8'd254, 16'd100);
      send_item(spq_pkg::KIND_INSERT, 8'd1, 16'd7);
      send_item(spq_pkg::KIND_INSERT, 8'd1, 16'd65534);
      drain_queue();
   endtask

   task automatic test_cursor_past_end();
      repeat (5) send_item(spq_pkg::KIND_DEQUEUE, 8'd0, 16'd0);
      // shrink the store below the cursor
      send_item(spq_pkg::KIND_REMOVE, 8'd2, 16'd0);
      send_item(spq_pkg::KIND_REMOVE, 8'd0, 16'd0);
      send_item(spq_pkg::KIND_DEQUEUE, 8'd0, 16'd0);
      send_item(spq_pkg::KIND_INSERT, 8'd9, 16'd3);
      send_item(spq_pkg::KIND_REFILL, 8'd0, 16'd0);
      send_item(spq_pkg::KIND_DEQUEUE, 8'd0, 16'd0);
      drain_queue();
   endtask

   task automatic test_full_store();
      send_item(spq_pkg::KIND_CLEAR, 8'd0, 16'd0);
      // descending priorities make every insert bubble to the head
      for (int i = 0; i < QDEPTH; i++) begin
         send_item(spq_pkg::KIND_INSERT, 8'(10 + i), 16'(65534 - i));
      end
      send_item(spq_pkg::KIND_INSERT, 8'd200, 16'd5);
      send_item(spq_pkg::KIND_INSERT, 8'd10, 16'd0);
      send_item(spq_pkg::KIND_REMOVE, 8'd200, 16'd0);
      send_item(spq_pkg::KIND_DEQUEUE, 8'd0, 16'd0);
      drain_queue();
   endtask

   task automatic test_stalled_output();
      idle_on      = 1'b0;
      hold_off_len = 400;
      run_random(30, 20);
      drain_queue();
      idle_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      for (int chunk = 0; chunk < 4; chunk++) begin
         run_random(350, (chunk % 2 == 0) ? 20 : 48);
         drain_queue();
      end
      idle_on = 1'b0;
      run_random(350, 20);
      drain_queue();
   endtask

   initial begin : rsp_ready_gen
      int stall_left;
      stall_left     = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_len != 0) begin
            stall_left   = hold_off_len;
            hold_off_len = 0;
         end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 8);
         end
         if (stall_left != 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : status_check
      queue_status_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_status.size() == 0) begin
            $error("response transaction with no request outstanding");
            fail_count++;
         end else begin
            want = pending_status.pop_front();
            check_field("out_value", 16'(want.out_value), 16'(rsp_chan.out_value));
            check_field("was_empty", 16'(want.was_empty), 16'(rsp_chan.was_empty));
            check_field("head_priority", want.head_priority, rsp_chan.head_priority);
            check_field("live_count", 16'(want.live_count), 16'(rsp_chan.live_count));
            check_field("full_reject", 16'(want.full_reject), 16'(rsp_chan.full_reject));
         end
      end
   end

   initial begin
      reset                  = 1'b1;
      req_chan.valid         = 1'b0;
      req_chan.kind          = spq_pkg::KIND_INSERT;
      req_chan.item_value    = '0;
      req_chan.item_priority = '0;
      wipe_shadow();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_empty_store();
      test_ordering();
      test_cursor_past_end();
      test_full_store();
      test_stalled_output();
      test_random_traffic();
      repeat (TAIL_WAIT) @(posedge clock);
      if (fail_count == 0) begin
         $display("sorted_priority_queue_16 verification clean");
      end else begin
         $display("sorted_priority_queue_16 verification failed");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("sorted_priority_queue_16 verification failed");
      $finish;
   end

endmodule
